>>> sv/relative_quaternion_axis_rotate_assert.svh
// assertion macros for the relative quaternion axis rotate block
// no dependencies; included by the port checker
`ifndef RELATIVE_QUATERNION_AXIS_ROTATE_ASSERT_SVH
`define RELATIVE_QUATERNION_AXIS_ROTATE_ASSERT_SVH

// generic clocked property, disabled while in reset
`define RQAR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// a stalled word keeps the given signal unchanged on the next edge
`define RQAR_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        ((vld) && !(rdy)) |=> $stable(sig)) else $error(msg);

`endif

>>> sv/rqar_pkg.sv
// types, constants and helpers for the relative quaternion axis rotate block
// no dependencies; used by the interfaces, the top level and the checker
package rqar_pkg;

    // register file
    localparam int NUM_REGS = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INIT_X = 3'd0,
        REG_INIT_Y = 3'd1,
        REG_INIT_Z = 3'd2,
        REG_INIT_W = 3'd3,
        REG_AXIS_X = 3'd4,
        REG_AXIS_Y = 3'd5,
        REG_AXIS_Z = 3'd6
    } cfg_idx_t;

    // fixed point widths along the datapath
    typedef logic signed [15:0] q_t;    // Q1.14 field
    typedef logic signed [31:0] p1_t;   // 16x16 product
    typedef logic signed [33:0] s1_t;   // sum of four products
    typedef logic signed [19:0] r_t;    // relative quaternion component
    typedef logic signed [39:0] p2_t;   // component product
    typedef logic signed [41:0] m_t;    // matrix entry, Q.28
    typedef logic signed [57:0] p3_t;   // entry times axis
    typedef logic signed [59:0] s3_t;   // sum of three, Q.42

    localparam q_t INIT_X_RST = 16'sd0;
    localparam q_t INIT_Y_RST = 16'sd0;
    localparam q_t INIT_Z_RST = 16'sd0;
    localparam q_t INIT_W_RST = 16'sd16384;
    localparam q_t AXIS_X_RST = 16'sd16384;
    localparam q_t AXIS_Y_RST = 16'sd0;
    localparam q_t AXIS_Z_RST = 16'sd0;

    localparam s1_t RND_14 = s1_t'(64'sd8192);
    localparam m_t ONE_Q28 = m_t'(64'sd268435456);
    localparam s3_t RND_28 = s3_t'(64'sd134217728);

    localparam int NUM_STAGES = 6;

    typedef struct packed {
        q_t cur_x;
        q_t cur_y;
        q_t cur_z;
        q_t cur_w;
    } cur_word_t;

    typedef struct packed {
        q_t dir_x;
        q_t dir_y;
        q_t dir_z;
    } dir_word_t;

    // saturate a Q.14 value that has grown to 32 bits
    function automatic q_t sat16(logic signed [31:0] v);
        logic hi_ok;
        hi_ok = (v[31:15] == {17{v[31]}});
        if (hi_ok)
            return v[15:0];
        else if (v[31])
            return 16'sh8000;
        else
            return 16'sh7fff;
    endfunction

endpackage

>>> sv/rqar_if.sv
// valid/ready channel interfaces for the relative quaternion axis rotate block
// depends on rqar_pkg for the payload types
interface rqar_cur_if
    import rqar_pkg::*;
();
    logic      valid;
    logic      ready;
    cur_word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface rqar_dir_if
    import rqar_pkg::*;
();
    logic      valid;
    logic      ready;
    dir_word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> sv/relative_quaternion_axis_rotate.sv
// relative quaternion axis rotate: top level, six stage pipeline
// depends on rqar_pkg and the channel interfaces in rqar_if.sv
//
//  channel | dir | word                              | handshake
//  cur     | in  | cur_x, cur_y, cur_z, cur_w (Q1.14)| valid/ready
//  dir     | out | dir_x, dir_y, dir_z (Q1.14, sat)  | valid/ready
//  cfg     | in  | cfg_idx, cfg_data                 | cfg_we, no back-pressure
//
// one word per cycle sustained while dir takes results; each word passes
// through six stages before it is valid on dir (a product and a sum stage each
// for the hamilton product, the matrix and the axis rotation)
// rst_n clears all valid bits and loads the register reset values
// a dir stall holds a full stage only when all later stages are full; bubbles collapse
module relative_quaternion_axis_rotate
    import rqar_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    rqar_cur_if.sink              cur,
    rqar_dir_if.source            dir,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    q_t init_reg [4];
    q_t axis_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg[0] <= INIT_X_RST;
            init_reg[1] <= INIT_Y_RST;
            init_reg[2] <= INIT_Z_RST;
            init_reg[3] <= INIT_W_RST;
            axis_reg[0] <= AXIS_X_RST;
            axis_reg[1] <= AXIS_Y_RST;
            axis_reg[2] <= AXIS_Z_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_INIT_X: init_reg[0] <= q_t'(cfg_data);
                REG_INIT_Y: init_reg[1] <= q_t'(cfg_data);
                REG_INIT_Z: init_reg[2] <= q_t'(cfg_data);
                REG_INIT_W: init_reg[3] <= q_t'(cfg_data);
                REG_AXIS_X: axis_reg[0] <= q_t'(cfg_data);
                REG_AXIS_Y: axis_reg[1] <= q_t'(cfg_data);
                REG_AXIS_Z: axis_reg[2] <= q_t'(cfg_data);
                default: ;
            endcase
        end
    end

    // stage valid bits and load enables
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] en;

    always_comb
    begin
        en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || dir.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next = vld_reg;
        if (en[0])
            vld_next[0] = cur.valid;
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (en[k])
                vld_next[k] = vld_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign cur.ready = en[0];

    // stage 0: all sixteen current x initial products
    q_t  cur_q [4];
    p1_t p1_next [4][4];
    p1_t p1_reg [4][4];

    always_comb
    begin
        cur_q[0] = cur.payload.cur_x;
        cur_q[1] = cur.payload.cur_y;
        cur_q[2] = cur.payload.cur_z;
        cur_q[3] = cur.payload.cur_w;
        for (int c = 0; c < 4; c++)
        begin
            for (int g = 0; g < 4; g++)
            begin
                p1_next[c][g] = p1_t'(cur_q[c]) * p1_t'(init_reg[g]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
            p1_reg <= p1_next;
    end

    // stage 1: hamilton product with the conjugate, rounded to Q.14
    // index order x, y, z, w
    s1_t s1_sum [4];
    r_t  rel_next [4];
    r_t  rel_reg [4];

    always_comb
    begin
        s1_sum[0] = -s1_t'(p1_reg[3][0]) + s1_t'(p1_reg[0][3])
                    - s1_t'(p1_reg[1][2]) + s1_t'(p1_reg[2][1]) + RND_14;
        s1_sum[1] = -s1_t'(p1_reg[3][1]) + s1_t'(p1_reg[0][2])
                    + s1_t'(p1_reg[1][3]) - s1_t'(p1_reg[2][0]) + RND_14;
        s1_sum[2] = -s1_t'(p1_reg[3][2]) - s1_t'(p1_reg[0][1])
                    + s1_t'(p1_reg[1][0]) + s1_t'(p1_reg[2][3]) + RND_14;
        s1_sum[3] = s1_t'(p1_reg[3][3]) + s1_t'(p1_reg[0][0])
                    + s1_t'(p1_reg[1][1]) + s1_t'(p1_reg[2][2]) + RND_14;
        for (int i = 0; i < 4; i++)
        begin
            rel_next[i] = s1_sum[i][33:14];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
            rel_reg <= rel_next;
    end

    // stage 2: component products for the rotation matrix
    p2_t xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            xx_reg <= p2_t'(rel_reg[0]) * p2_t'(rel_reg[0]);
            yy_reg <= p2_t'(rel_reg[1]) * p2_t'(rel_reg[1]);
            zz_reg <= p2_t'(rel_reg[2]) * p2_t'(rel_reg[2]);
            xy_reg <= p2_t'(rel_reg[0]) * p2_t'(rel_reg[1]);
            xz_reg <= p2_t'(rel_reg[0]) * p2_t'(rel_reg[2]);
            yz_reg <= p2_t'(rel_reg[1]) * p2_t'(rel_reg[2]);
            wx_reg <= p2_t'(rel_reg[3]) * p2_t'(rel_reg[0]);
            wy_reg <= p2_t'(rel_reg[3]) * p2_t'(rel_reg[1]);
            wz_reg <= p2_t'(rel_reg[3]) * p2_t'(rel_reg[2]);
        end
    end

    // stage 3: matrix entries in Q.28, mat[row][col]
    m_t mat_next [3][3];
    m_t mat_reg [3][3];

    always_comb
    begin
        mat_next[0][0] = ONE_Q28 - ((m_t'(yy_reg) + m_t'(zz_reg)) <<< 1);
        mat_next[0][1] = (m_t'(xy_reg) + m_t'(wz_reg)) <<< 1;
        mat_next[0][2] = (m_t'(xz_reg) - m_t'(wy_reg)) <<< 1;
        mat_next[1][0] = (m_t'(xy_reg) - m_t'(wz_reg)) <<< 1;
        mat_next[1][1] = ONE_Q28 - ((m_t'(xx_reg) + m_t'(zz_reg)) <<< 1);
        mat_next[1][2] = (m_t'(yz_reg) + m_t'(wx_reg)) <<< 1;
        mat_next[2][0] = (m_t'(xz_reg) + m_t'(wy_reg)) <<< 1;
        mat_next[2][1] = (m_t'(yz_reg) - m_t'(wx_reg)) <<< 1;
        mat_next[2][2] = ONE_Q28 - ((m_t'(xx_reg) + m_t'(yy_reg)) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
            mat_reg <= mat_next;
    end

    // stage 4: axis component times matrix row
    p3_t p3_next [3][3];
    p3_t p3_reg [3][3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                p3_next[r][c] = p3_t'(axis_reg[r]) * p3_t'(mat_reg[r][c]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
            p3_reg <= p3_next;
    end

    // stage 5: column sums, round to Q.14, saturate into the output word
    s3_t       s3_sum [3];
    dir_word_t dir_next;
    dir_word_t dir_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            s3_sum[c] = s3_t'(p3_reg[0][c]) + s3_t'(p3_reg[1][c])
                        + s3_t'(p3_reg[2][c]) + RND_28;
        end
        dir_next.dir_x = sat16(s3_sum[0][59:28]);
        dir_next.dir_y = sat16(s3_sum[1][59:28]);
        dir_next.dir_z = sat16(s3_sum[2][59:28]);
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
            dir_reg <= dir_next;
    end

    assign dir.valid   = vld_reg[NUM_STAGES-1];
    assign dir.payload = dir_reg;

endmodule

>>> sv/rqar_chk.sv
// port checker for the relative quaternion axis rotate block, with its bind
// depends on rqar_pkg and the assertion macros header
`include "relative_quaternion_axis_rotate_assert.svh"

module rqar_chk
    import rqar_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      cur_valid,
    input logic      cur_ready,
    input logic      dir_valid,
    input logic      dir_ready,
    input dir_word_t dir_payload
);

    // words accepted on cur and not yet taken from dir
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic       acc_in;
    logic       acc_out;

    assign acc_in  = cur_valid && cur_ready;
    assign acc_out = dir_valid && dir_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (acc_in && !acc_out)
            cnt_next = cnt_reg + 3'd1;
        else if (!acc_in && acc_out)
            cnt_next = cnt_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // never more words in flight than pipeline stages
    `RQAR_ASSERT(a_cnt_max, clk, rst_n, cnt_reg <= 3'(NUM_STAGES), "too many words in flight")
    // a result word only for an accepted input word
    `RQAR_ASSERT(a_no_phantom, clk, rst_n, dir_valid |-> (cnt_reg != 3'd0), "result without input")
    // with nothing waiting on dir the input side is open
    `RQAR_ASSERT(a_ready_free, clk, rst_n, !dir_valid |-> cur_ready, "input blocked while output empty")
    // a stalled result keeps its valid and data
    `RQAR_ASSERT_HOLD(a_vld_hold, clk, rst_n, dir_valid, dir_ready, dir_valid, "valid dropped in stall")
    `RQAR_ASSERT_HOLD(a_dat_hold, clk, rst_n, dir_valid, dir_ready, dir_payload, "word changed in stall")

endmodule

bind relative_quaternion_axis_rotate rqar_chk u_rqar_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cur_valid   (cur.valid),
    .cur_ready   (cur.ready),
    .dir_valid   (dir.valid),
    .dir_ready   (dir.ready),
    .dir_payload (dir.payload)
);
